[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every check is clocked on a rising edge and is held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the first expression holds, the second must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// When the first expression holds, the second must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/mssd_pkg.sv]
package mssd_pkg;

    localparam int DEF_NUM_DIGITS = 4;
    localparam int DEF_RADIX      = 10;

    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam int REM_W      = 5;
    localparam int WORD_W     = 16;
    localparam int BIT_CNT_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ZEROS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DP_DIGIT    = 2'd1;

    localparam logic [1:0] DP_DIGIT_RESET = 2'd1;
    localparam logic [7:0] SEL_ONE        = 8'h01;
    localparam logic [7:0] SEG_DP         = 8'h80;
    localparam logic [7:0] SEG_NONE       = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_SHIFT
    } t_state;

    // Seven-segment glyphs, segment a in bit 0. Hex glyphs only appear with a radix above ten.
    function automatic logic [7:0] seg_lut(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h39;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            4'hF: seg = 8'h71;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

[hw/rtl/mssd_divider.sv]
module mssd_divider
    import mssd_pkg::*;
#(
    parameter int RADIX = DEF_RADIX
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [VALUE_W-1:0] i_num,
    output logic [VALUE_W-1:0] o_quo,
    output logic [REM_W-1:0]   o_rem
);

    // Reciprocal scaled by 2^16; the estimate is low by at most one.
    localparam int RECIP = (1 << VALUE_W) / RADIX;

    localparam logic [VALUE_W-1:0]   DIVISOR = VALUE_W'(RADIX);
    localparam logic [VALUE_W-1:0]   RECIP_C = VALUE_W'(RECIP);

    logic [VALUE_W-1:0]   r_num;
    logic [2*VALUE_W-1:0] r_prod;
    logic [VALUE_W-1:0]   w_est;
    logic [VALUE_W-1:0]   w_back;
    logic [VALUE_W-1:0]   w_diff;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num  <= i_num;
            r_prod <= i_num * RECIP_C;
        end
    end

    always_comb begin
        w_est  = r_prod[2*VALUE_W-1:VALUE_W];
        w_back = VALUE_W'(w_est * DIVISOR);
        w_diff = r_num - w_back;
        if (w_diff >= DIVISOR) begin
            o_quo = w_est + VALUE_W'(1);
            o_rem = REM_W'(w_diff - DIVISOR);
        end else begin
            o_quo = w_est;
            o_rem = REM_W'(w_diff);
        end
    end

endmodule

[hw/rtl/muxed_seven_segment_shift_driver.sv]
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_display_value
// output    out        o_valid / i_ready          o_serial_bit, o_latch_pulse
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An item at digit position p first goes through digit extraction and then shifts
// out its 16-bit word, one serial bit per cycle when the receiver is ready. The
// shared divide-by-radix unit does the extraction: p+1 divisions, each a multiply
// state (ST_MUL) followed by a correction state (ST_FIX).
// A blanked digit finishes after the division that yields its own quotient and sends nothing.
// Reset is synchronous and active low; it clears the position, blanking and the sequencer.
// A stalled output simply holds the current bit; no new item is taken until all 16 bits leave.
`include "assert_macros.svh"

module muxed_seven_segment_shift_driver
    import mssd_pkg::*;
#(
    parameter int NUM_DIGITS = DEF_NUM_DIGITS,
    parameter int RADIX      = DEF_RADIX
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_W-1:0]    i_display_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_serial_bit,
    output logic                  o_latch_pulse,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_DIGITS - 1);

    t_state r_state;
    t_state n_state;

    logic [PW-1:0]        r_pos;
    logic [PW-1:0]        r_cnt;
    logic                 r_blank;
    logic [1:0]           r_dp;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [VALUE_W-1:0]   r_quo;
    logic [WORD_W-1:0]    r_word;

    logic [VALUE_W-1:0]   w_quo;
    logic [REM_W-1:0]     w_rem;
    logic                 w_skip;
    logic                 w_fire;
    logic                 w_last;
    logic                 w_done;
    logic [7:0]           w_sel;
    logic [7:0]           w_seg;

    // The one shared unit: each pass divides the running quotient by the radix.
    mssd_divider #(
        .RADIX (RADIX)
    ) u_div (
        .i_clk  (i_clk),
        .i_load (r_state == ST_MUL),
        .i_num  (r_quo),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    // The pass that yields the digit's own quotient also decides leading-zero blanking.
    assign w_skip = (r_state == ST_FIX) && (r_cnt == PW'(1)) && r_blank
                    && (r_pos > PW'(1)) && (w_quo == '0);
    assign w_fire = o_valid && i_ready;
    assign w_last = w_fire && (r_bit == BIT_CNT_W'(WORD_W - 1));
    assign w_done = w_skip || w_last;

    // Select byte has the current digit's bit low; the segment byte may carry the point.
    always_comb begin
        w_sel = ~(SEL_ONE << r_pos);
        w_seg = seg_lut(w_rem[3:0])
                | ((4'(r_pos) == 4'(r_dp)) ? SEG_DP : SEG_NONE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_FIX;
            end
            ST_FIX: begin
                if (w_skip) begin
                    n_state = ST_IDLE;
                end else if (r_cnt == '0) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_SHIFT: begin
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        o_cfg_ready   = 1'b1;
        o_serial_bit  = r_word[WORD_W-1];
        o_latch_pulse = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_SHIFT: begin
                o_valid       = 1'b1;
                o_latch_pulse = (r_bit == BIT_CNT_W'(WORD_W - 1));
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_blank <= 1'b0;
            r_dp    <= DP_DIGIT_RESET;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLANK_ZEROS) begin
                    r_blank <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_DP_DIGIT) begin
                    r_dp <= i_cfg_data[1:0];
                end
            end
            if (r_state == ST_IDLE && i_valid) begin
                r_cnt <= r_pos;
            end else if (r_state == ST_FIX && r_cnt != '0) begin
                r_cnt <= r_cnt - PW'(1);
            end
            if (r_state == ST_FIX && r_cnt == '0) begin
                r_bit <= '0;
            end else if (w_fire) begin
                r_bit <= r_bit + BIT_CNT_W'(1);
            end
            if (w_done) begin
                r_pos <= (r_pos == LAST_POS) ? '0 : r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_quo <= i_display_value;
        end else if (r_state == ST_FIX && r_cnt != '0) begin
            r_quo <= w_quo;
        end
        if (r_state == ST_FIX && r_cnt == '0) begin
            r_word <= {w_sel, w_seg};
        end else if (w_fire) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
        end
    end

    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, r_pos <= LAST_POS, "digit position out of range")
    `ASSERT_IMPL(a_digit_range, i_clk, i_rst_n, r_state == ST_FIX, w_rem < REM_W'(RADIX), "digit not below radix")
    `ASSERT_IMPL(a_one_side, i_clk, i_rst_n, o_ready, !o_valid, "item taken while bits still pending")
    `ASSERT_NEXT(a_latch_ends, i_clk, i_rst_n, w_fire && o_latch_pulse, o_ready && !o_valid, "run did not end after latch bit")

endmodule

[bench/muxed_seven_segment_shift_driver_test.sv]
module muxed_seven_segment_shift_driver_test;
    import mssd_pkg::*;

    // The block exposes only two register indexes. The other two index codes
    // exist on the port and must be ignored, so they get names of their own.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int DIGITS      = 4;
    localparam int BASE        = 10;
    localparam int IDLE_PCT    = 30;
    // The settle wait after draining lets a blanked last digit finish its
    // extraction and retire without sending anything.
    localparam int SETTLE_CYC  = 40;
    // The receiver hold-off must be much longer than one frame, so the block
    // stalls its input while the sender keeps offering items.
    localparam int RX_HOLD_CYC = 300;

    // Segment patterns for the decimal digits, segment a in bit 0.
    localparam logic [7:0] GLYPH [BASE] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic data;
        logic last;
    } t_shift_bit;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  o_ready;
    logic [VALUE_W-1:0]    i_display_value = '0;
    logic                  o_valid;
    logic                  i_ready         = 1'b0;
    logic                  o_serial_bit;
    logic                  o_latch_pulse;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // Values waiting to be offered on the input channel, and the serial bits
    // that the accepted values are expected to produce, oldest first.
    logic [VALUE_W-1:0] values_to_send [$];
    t_shift_bit         shift_bits_due [$];

    // Shadow of the block: its rotating digit position and both registers.
    int unsigned digit_pos   = 0;
    logic        blank_zeros = 1'b0;
    logic [1:0]  dp_digit    = DP_DIGIT_RESET;

    // Run controls set by the stimulus process on falling edges, and the receiver's hold count.
    bit steady    = 1'b0;
    bit hold_kick = 1'b0;
    int hold_left = 0;

    int errors        = 0;
    int values_taken  = 0;
    int bits_checked  = 0;
    int digits_blank  = 0;
    int frames_built  = 0;
    int reg_writes    = 0;

    muxed_seven_segment_shift_driver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_display_value (i_display_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_serial_bit    (o_serial_bit),
        .o_latch_pulse   (o_latch_pulse),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Register write as the block sees it: only the low bits of each
    // register survive, and spare indexes leave everything untouched.
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BLANK_ZEROS: blank_zeros = data[0];
            CFG_DP_DIGIT:    dp_digit    = data[1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Works out the 16-bit frame for one refresh tick at the current digit
    // position and queues its bits, most significant first. A leading zero
    // above the tens digit is dropped when blanking is on; the position
    // still moves on in that case.
    task automatic encode_digit_frame(input logic [VALUE_W-1:0] value);
        int unsigned quot;
        logic [7:0]  sel;
        logic [7:0]  seg;
        logic [15:0] frame;
        quot = 32'(value);
        for (int k = 0; k < digit_pos; k++) begin
            quot = quot / BASE;
        end
        if (blank_zeros && digit_pos > 1 && quot == 0) begin
            digits_blank++;
        end else begin
            sel = ~(SEL_ONE << digit_pos);
            seg = GLYPH[4'(quot % BASE)];
            if (digit_pos == dp_digit) begin
                seg = seg | SEG_DP;
            end
            frame = {sel, seg};
            for (int k = 15; k >= 0; k--) begin
                shift_bits_due.push_back('{data: frame[k], last: (k == 0)});
            end
            frames_built++;
        end
        digit_pos = (digit_pos == DIGITS - 1) ? 0 : digit_pos + 1;
    endtask

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Each serial bit leaving the block is matched against the oldest
    // expectation, data and latch flag separately.
    task automatic check_bit(input logic sbit, input logic latch);
        t_shift_bit want;
        if (shift_bits_due.size() == 0) begin
            note_mismatch($sformatf("unexpected bit data=%b latch=%b", sbit, latch));
        end else begin
            want = shift_bits_due.pop_front();
            if (want.data !== sbit) begin
                note_mismatch($sformatf("serial bit expected %b got %b",
                                        want.data, sbit));
            end
            if (want.last !== latch) begin
                note_mismatch($sformatf("latch pulse expected %b got %b",
                                        want.last, latch));
            end
        end
        bits_checked++;
    endtask

    // Input driver. A new value is offered only when the channel is empty or
    // the current item is being taken at this edge, so valid never drops
    // while an item is waiting, and it is assigned once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (values_to_send.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_valid         <= 1'b1;
                i_display_value <= values_to_send.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output receiver. It normally stalls at random; when asked, it holds
    // ready low for a long counted stretch so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            i_ready   <= 1'b0;
            hold_left <= RX_HOLD_CYC;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor. All three channels are sampled at the same edge at which the
    // handshake completes, before any of this edge's updates take effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(i_cfg_index, i_cfg_data);
            end
            if (i_valid && o_ready) begin
                values_taken++;
                encode_digit_frame(i_display_value);
            end
            if (o_valid && i_ready) begin
                check_bit(o_serial_bit, o_latch_pulse);
            end
        end
    end

    // Register write, held until the block takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued value has been taken and every expected bit
    // has left, then lets a possibly blanked last digit finish as well.
    task automatic wait_drained;
        @(negedge i_clk);
        while (values_to_send.size() != 0 || i_valid || shift_bits_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Random values lean toward small numbers so that blanking of the upper
    // digits happens often, while full-width values still reach every bit.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(4))
            0:       return VALUE_W'($urandom_range(9));
            1:       return VALUE_W'($urandom_range(99));
            2:       return VALUE_W'($urandom_range(999));
            3:       return VALUE_W'($urandom_range(9999));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic queue_random(input int count);
        @(negedge i_clk);
        repeat (count) values_to_send.push_back(pick_value());
    endtask

    task automatic queue_repeated(input logic [VALUE_W-1:0] value);
        @(negedge i_clk);
        repeat (DIGITS) values_to_send.push_back(value);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, default settings written back explicitly. Each value
        // is sent once per digit position, so the whole number is shown.
        // Zero, a value with a distinct digit everywhere, and the largest value.
        write_reg(CFG_BLANK_ZEROS, 2'd0);
        write_reg(CFG_DP_DIGIT, DP_DIGIT_RESET);
        queue_repeated(16'd0);
        queue_repeated(16'd9876);
        queue_repeated(16'hFFFF);
        wait_drained();

        // Blanking on with the decimal point on the top digit. A single digit
        // blanks both upper positions; a three-digit value blanks only the top.
        // The spare indexes are written with values that would otherwise show.
        write_reg(CFG_BLANK_ZEROS, 2'd1);
        write_reg(CFG_DP_DIGIT, 2'd3);
        write_reg(CFG_SPARE_LO, 2'd0);
        write_reg(CFG_SPARE_HI, 2'd2);
        queue_repeated(16'd7);
        queue_repeated(16'd123);
        wait_drained();

        // Random part. First a stretch where neither side ever idles.
        write_reg(CFG_BLANK_ZEROS, 2'd0);
        write_reg(CFG_DP_DIGIT, 2'd1);
        @(negedge i_clk);
        steady = 1'b1;
        queue_random(60);
        wait_drained();
        @(negedge i_clk);
        steady = 1'b0;

        // The receiver holds off for a long time while the sender keeps
        // offering, so the block fills up and stops taking items.
        write_reg(CFG_BLANK_ZEROS, 2'd1);
        write_reg(CFG_DP_DIGIT, 2'd0);
        queue_random(60);
        @(negedge i_clk);
        hold_kick = 1'b1;
        while (hold_left == 0) @(negedge i_clk);
        hold_kick = 1'b0;
        wait_drained();

        // Blanking data wider than its register: only the low bit counts,
        // so a two turns blanking off and a three turns it back on.
        write_reg(CFG_BLANK_ZEROS, 2'd2);
        write_reg(CFG_DP_DIGIT, 2'd2);
        queue_random(60);
        wait_drained();

        write_reg(CFG_BLANK_ZEROS, 2'd3);
        write_reg(CFG_DP_DIGIT, 2'd3);
        queue_random(60);
        wait_drained();

        write_reg(CFG_SPARE_HI, 2'd1);
        write_reg(CFG_DP_DIGIT, 2'd2);
        queue_random(60);
        wait_drained();

        write_reg(CFG_BLANK_ZEROS, 2'd0);
        write_reg(CFG_DP_DIGIT, 2'd0);
        queue_random(60);
        wait_drained();

        $display("Took %0d display values: %0d frames, %0d blanked digits, %0d bits checked.",
                 values_taken, frames_built, digits_blank, bits_checked);
        $display("Applied %0d register writes, %0d errors counted.", reg_writes, errors);
        if (errors == 0 && shift_bits_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
